// ===== design/recent_lba_locality_classifier_top_assert.svh =====
// assertion macros for the recent lba locality classifier
`ifndef RECENT_LBA_LOCALITY_CLASSIFIER_TOP_ASSERT_SVH
`define RECENT_LBA_LOCALITY_CLASSIFIER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define RLC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlc assertion failed");

// antecedent implies consequent in the next cycle
`define RLC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlc assertion failed");

`else

`define RLC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RLC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/rlc_pkg.sv =====
// shared types and constants for the recent lba locality classifier
package rlc_pkg;

    localparam int unsigned LBA_W     = 48;
    localparam int unsigned CFG_W     = 49;
    localparam int unsigned RCNT_W    = 7;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_BLOCKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECENT_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd2;

    localparam logic [CFG_W-1:0]  VOLUME_RST = 49'h1_0000_0000_0000;
    localparam logic [RCNT_W-1:0] RECENT_RST = 7'd64;
    localparam logic [CFG_W-1:0]  WINDOW_RST = 49'd1;

    localparam logic [CNT_W-1:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_dist_ctl;

    typedef struct packed {
        logic busy;
    } t_dist_sts;

endpackage

// ===== design/recent_lba_locality_classifier_top.sv =====
// recent lba locality classifier top: history memory, sequencer and counters
// a word that only fills the history is stored on accept and its result is issued from S_OUT;
// a judged word passes S_READ, S_DRAIN, S_FINISH, S_MOD and S_OUT; new words wait for S_IDLE;
// the history is walked one entry per cycle through its single read port into the distance
// unit, and S_MOD subtracts the clamped count repeatedly when the oldest slot wraps
// synchronous active-low reset clears control state and counters; no clearing pass
`include "recent_lba_locality_classifier_top_assert.svh"

module recent_lba_locality_classifier_top
    import rlc_pkg::*;
#(
    parameter int unsigned MAX_RECENT = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [LBA_W-1:0]     i_lba,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_classified,
    output logic                 o_is_near,
    output logic [CNT_W-1:0]     o_near_total,
    output logic [CNT_W-1:0]     o_judged_total
);

    localparam int unsigned CW = $clog2(MAX_RECENT + 1);
    localparam int unsigned AW = (MAX_RECENT > 1) ? $clog2(MAX_RECENT) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_FINISH,
        S_MOD,
        S_OUT
    } t_state;

    logic [CFG_W-1:0]  r_volume;
    logic [RCNT_W-1:0] r_recent;
    logic [CFG_W-1:0]  r_window;

    t_state            r_state,      n_state;
    logic [CW-1:0]     r_fill,       n_fill;
    logic [AW-1:0]     r_slot,       n_slot;
    logic [AW-1:0]     r_k,          n_k;
    logic [CW-1:0]     r_mod,        n_mod;
    logic [LBA_W-1:0]  r_lba,        n_lba;
    logic              r_cls,        n_cls;
    logic              r_near,       n_near;
    logic [CNT_W-1:0]  r_near_cnt,   n_near_cnt;
    logic [CNT_W-1:0]  r_judged_cnt, n_judged_cnt;
    logic              r_rd_vld,     n_rd_vld;
    logic              r_out_valid,  n_out_valid;
    logic              r_o_cls,      n_o_cls;
    logic              r_o_near,     n_o_near;
    logic [CNT_W-1:0]  r_o_near_tot, n_o_near_tot;
    logic [CNT_W-1:0]  r_o_judg_tot, n_o_judg_tot;

    logic [LBA_W-1:0]  r_mem [MAX_RECENT];
    logic [LBA_W-1:0]  r_rd_data;

    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [LBA_W-1:0]  w_mem_wdata;
    logic [CW-1:0]     w_eff;
    logic              w_is_near;
    logic [CFG_W-1:0]  w_best;
    t_dist_ctl         w_dist_ctl;
    t_dist_sts         w_dist_sts;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume <= VOLUME_RST;
            r_recent <= RECENT_RST;
            r_window <= WINDOW_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_VOLUME_BLOCKS: r_volume <= i_cfg_wdata;
                CFG_RECENT_COUNT:  r_recent <= i_cfg_wdata[RCNT_W-1:0];
                CFG_WINDOW_SIZE:   r_window <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // recent_count clamped to 1..MAX_RECENT
    always_comb begin
        if (r_recent == '0) begin
            w_eff = CW'(1);
        end else if (32'(r_recent) > 32'(MAX_RECENT)) begin
            w_eff = CW'(MAX_RECENT);
        end else begin
            w_eff = CW'(r_recent);
        end
    end

    assign w_is_near = (w_best < r_window);

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_slot       = r_slot;
        n_k          = r_k;
        n_mod        = r_mod;
        n_lba        = r_lba;
        n_cls        = r_cls;
        n_near       = r_near;
        n_near_cnt   = r_near_cnt;
        n_judged_cnt = r_judged_cnt;
        n_rd_vld     = 1'b0;
        n_out_valid  = r_out_valid & i_out_stall;
        n_o_cls      = r_o_cls;
        n_o_near     = r_o_near;
        n_o_near_tot = r_o_near_tot;
        n_o_judg_tot = r_o_judg_tot;
        w_mem_we     = 1'b0;
        w_mem_waddr  = r_slot;
        w_mem_wdata  = r_lba;
        w_dist_ctl   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_lba = i_lba;
                    if (r_fill < w_eff) begin
                        // history still filling: store only
                        w_mem_we    = 1'b1;
                        w_mem_waddr = r_fill[AW-1:0];
                        w_mem_wdata = i_lba;
                        n_fill      = r_fill + CW'(1);
                        n_slot      = '0;
                        n_cls       = 1'b0;
                        n_near      = 1'b0;
                        n_state     = S_OUT;
                    end else begin
                        w_dist_ctl.clear = 1'b1;
                        n_k              = '0;
                        n_state          = S_READ;
                    end
                end
            end
            S_READ: begin
                n_rd_vld = 1'b1;
                n_k      = r_k + AW'(1);
                if ((CW'(r_k) + CW'(1)) == r_fill) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_vld && !w_dist_sts.busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_cls  = 1'b1;
                n_near = w_is_near;
                if (w_is_near && (r_near_cnt != CNT_MAX)) begin
                    n_near_cnt = r_near_cnt + CNT_W'(1);
                end
                if (r_judged_cnt != CNT_MAX) begin
                    n_judged_cnt = r_judged_cnt + CNT_W'(1);
                end
                w_mem_we    = 1'b1;
                w_mem_waddr = r_slot;
                w_mem_wdata = r_lba;
                n_mod       = CW'(r_slot) + CW'(1);
                n_state     = S_MOD;
            end
            S_MOD: begin
                // slot + 1 modulo the clamped count by repeated subtraction
                if (r_mod >= w_eff) begin
                    n_mod = r_mod - w_eff;
                end else begin
                    n_slot  = r_mod[AW-1:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_o_cls      = r_cls;
                    n_o_near     = r_near;
                    n_o_near_tot = r_near_cnt;
                    n_o_judg_tot = r_judged_cnt;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        w_dist_ctl.valid = r_rd_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fill       <= '0;
            r_slot       <= '0;
            r_near_cnt   <= '0;
            r_judged_cnt <= '0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_fill       <= n_fill;
            r_slot       <= n_slot;
            r_near_cnt   <= n_near_cnt;
            r_judged_cnt <= n_judged_cnt;
            r_rd_vld     <= n_rd_vld;
            r_out_valid  <= n_out_valid;
        end
        r_k          <= n_k;
        r_mod        <= n_mod;
        r_lba        <= n_lba;
        r_cls        <= n_cls;
        r_near       <= n_near;
        r_o_cls      <= n_o_cls;
        r_o_near     <= n_o_near;
        r_o_near_tot <= n_o_near_tot;
        r_o_judg_tot <= n_o_judg_tot;
    end

    // history memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_mem[r_k];
        end
    end

    rlc_dist_unit u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dist_ctl),
        .i_a     (r_lba),
        .i_b     (r_rd_data),
        .i_cap   (r_volume[CFG_W-1:1]),
        .i_init  (r_volume),
        .o_best  (w_best),
        .o_sts   (w_dist_sts)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_classified   = r_o_cls;
    assign o_is_near      = r_o_near;
    assign o_near_total   = r_o_near_tot;
    assign o_judged_total = r_o_judg_tot;

    `RLC_ASSERT_IMP(a_near_le_judged, i_clk, i_rst_n, 1'b1, r_near_cnt <= r_judged_cnt)
    `RLC_ASSERT_IMP(a_slot_below_fill, i_clk, i_rst_n, (r_state == S_IDLE) && (r_fill != '0), CW'(r_slot) < r_fill)
    `RLC_ASSERT_IMP(a_unjudged_not_near, i_clk, i_rst_n, o_out_valid && !o_classified, !o_is_near)
    `RLC_ASSERT_NXT(a_read_feeds_unit, i_clk, i_rst_n, r_state == S_READ, r_rd_vld)

endmodule

// ===== design/rlc_dist_unit.sv =====
// pipelined capped distance and running minimum unit
module rlc_dist_unit
    import rlc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dist_ctl        i_ctl,
    input  logic [LBA_W-1:0] i_a,
    input  logic [LBA_W-1:0] i_b,
    input  logic [LBA_W-1:0] i_cap,
    input  logic [CFG_W-1:0] i_init,
    output logic [CFG_W-1:0] o_best,
    output t_dist_sts        o_sts
);

    logic [LBA_W:0]   w_ab;
    logic [LBA_W-1:0] w_ba;
    logic [LBA_W-1:0] w_abs;
    logic [LBA_W-1:0] w_capped;

    logic             r_s1_vld;
    logic [LBA_W-1:0] r_s1_abs;
    logic             r_s2_vld;
    logic [LBA_W-1:0] r_s2_dist;
    logic [CFG_W-1:0] r_best;

    assign w_ab     = {1'b0, i_a} - {1'b0, i_b};
    assign w_ba     = i_b - i_a;
    assign w_abs    = w_ab[LBA_W] ? w_ba : w_ab[LBA_W-1:0];
    assign w_capped = (r_s1_abs >= i_cap) ? i_cap : r_s1_abs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_ctl.valid;
            r_s2_vld <= r_s1_vld;
        end
        r_s1_abs  <= w_abs;
        r_s2_dist <= w_capped;
        if (i_ctl.clear) begin
            r_best <= i_init;
        end else if (r_s2_vld && ({1'b0, r_s2_dist} < r_best)) begin
            r_best <= {1'b0, r_s2_dist};
        end
    end

    assign o_best      = r_best;
    assign o_sts.busy  = r_s1_vld | r_s2_vld;

endmodule
